// ===== hw/rtl/sorted_priority_queue_assert.svh =====
// Assertion macros shared by the checker of the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sorted priority queue: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sorted priority queue: next-cycle check failed");

`endif

// ===== hw/rtl/spq_pkg.sv =====
// Shared types and constants of the sorted priority queue.
package spq_pkg;

	typedef enum logic [1:0] {
		OPC_PUT  = 2'd0,
		OPC_GET  = 2'd1,
		OPC_PEEK = 2'd2,
		OPC_NONE = 2'd3
	} opcode_t;

	localparam int OPCODE_W   = 2;
	localparam int PRIO_IN_W  = 32;
	localparam int PAY_IN_W   = 32;
	localparam int PAY_OUT_W  = 32;
	localparam int COUNT_W    = 7;
	localparam int S_TDATA_W  = 64;
	localparam int M_TDATA_W  = 48;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic put;
		logic get;
	} cell_ctl_t;

endpackage

// ===== hw/rtl/spq_cell.sv =====
// One slot of the sorted chain: holds an entry and shifts it to or from its neighbors.
module spq_cell
	import spq_pkg::*;
#(
	parameter int PRIO_W = 32,
	parameter int PAY_W  = 32
) (
	input  logic              clk,
	input  cell_ctl_t         ctl,
	input  logic              valid,
	input  logic [PRIO_W-1:0] new_key,
	input  logic [PAY_W-1:0]  new_pay,
	input  logic              prev_geq,
	input  logic [PRIO_W-1:0] prev_key,
	input  logic [PAY_W-1:0]  prev_pay,
	input  logic [PRIO_W-1:0] next_key,
	input  logic [PAY_W-1:0]  next_pay,
	output logic [PRIO_W-1:0] key,
	output logic [PAY_W-1:0]  pay,
	output logic              geq
);

	logic [PRIO_W-1:0] key_q;
	logic [PAY_W-1:0]  pay_q;

	// Cells are ordered highest first; equal priorities stay ahead of a new entry.
	assign geq = valid && ($signed(key_q) >= $signed(new_key));
	assign key = key_q;
	assign pay = pay_q;

	always_ff @(posedge clk) begin
		if (ctl.put) begin
			if (!geq && prev_geq) begin
				key_q <= new_key;
				pay_q <= new_pay;
			end else if (!geq) begin
				key_q <= prev_key;
				pay_q <= prev_pay;
			end
		end else if (ctl.get) begin
			key_q <= next_key;
			pay_q <= next_pay;
		end
	end

endmodule

// ===== hw/rtl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: cell chain, entry count and result register.
//
// Usage:
// Requests arrive on the s_ stream: s_tuser carries the opcode (put, get, peek),
// s_tdata the signed priority and the payload handle used by a put.
// Every request yields exactly one result on the m_ stream: the payload of the
// highest entry for a get or peek, a found flag, the entry count after the request,
// an empty flag and a dropped flag for a put into a full queue.
// The result is registered and presented in the cycle after the request transfer.
// One request per cycle while the result register is free or being drained. Every
// cell compares its entry with the new priority in parallel and shifts by one place,
// whatever the chain length; the highest entry always sits in cell 0.
// Equal priorities are served oldest first.
// Reset clears the entry count and the result valid flag; the cells need no clearing
// because only cells below the count are ever used.
// When the receiver stalls, hold the result; a new request is still taken while the
// result register is being drained in the same cycle, and otherwise s_tready drops.
module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int CAPACITY      = 64,
	parameter int PRIORITY_BITS = 32,
	parameter int PAYLOAD_BITS  = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // [31:0] priority_req, [63:32] payload
	input  logic [OPCODE_W-1:0]  s_tuser,  // [1:0] opcode
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [31:0] out_payload, [32] found, [39:33] entry_count, [40] is_empty,
	// [41] dropped, [47:42] zero
	output logic [M_TDATA_W-1:0] m_tdata
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic                     accept;
	opcode_t                  opcode;
	logic [PRIO_IN_W-1:0]     prio_in;
	logic [PAY_IN_W-1:0]      pay_in;
	logic [PRIORITY_BITS+PRIO_IN_W-1:0] prio_ext;
	logic [PAYLOAD_BITS+PAY_IN_W-1:0]   pay_ext;
	logic [PRIORITY_BITS-1:0] new_key;
	logic [PAYLOAD_BITS-1:0]  new_pay;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic             full;
	logic             empty;
	cell_ctl_t        ctl;

	logic [PRIORITY_BITS-1:0] cell_key [CAPACITY];
	logic [PAYLOAD_BITS-1:0]  cell_pay [CAPACITY];
	logic                     cell_geq [CAPACITY];

	logic [PAYLOAD_BITS+PAY_OUT_W-1:0] top_ext;
	logic [CNT_W+COUNT_W-1:0]          cnt_ext;
	logic                    found;
	logic                    dropped;
	logic [PAY_OUT_W-1:0]    out_payload;
	logic                    m_valid_q;
	logic [M_TDATA_W-1:0]    m_data_q;

	// Take a new request whenever the result register is free or being drained.
	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign opcode  = opcode_t'(s_tuser);
	assign prio_in = s_tdata[PRIO_IN_W-1:0];
	assign pay_in  = s_tdata[PRIO_IN_W+PAY_IN_W-1:PRIO_IN_W];

	// Sign-extend the priority, zero-extend the payload, then keep the stored width.
	assign prio_ext = {{PRIORITY_BITS{prio_in[PRIO_IN_W-1]}}, prio_in};
	assign pay_ext  = {{PAYLOAD_BITS{1'b0}}, pay_in};
	assign new_key  = prio_ext[PRIORITY_BITS-1:0];
	assign new_pay  = pay_ext[PAYLOAD_BITS-1:0];

	assign full  = (count_q == CNT_W'(CAPACITY));
	assign empty = (count_q == '0);

	// Decode the request into chain commands and the next entry count.
	always_comb begin
		ctl.put = 1'b0;
		ctl.get = 1'b0;
		found   = 1'b0;
		dropped = 1'b0;
		count_d = count_q;
		case (opcode)
			OPC_PUT: begin
				if (full) begin
					dropped = 1'b1;
				end else begin
					ctl.put = accept;
					count_d = count_q + CNT_W'(1);
				end
			end
			OPC_GET: begin
				if (!empty) begin
					ctl.get = accept;
					found   = 1'b1;
					count_d = count_q - CNT_W'(1);
				end
			end
			OPC_PEEK: begin
				found = !empty;
			end
			default: begin
			end
		endcase
	end

	// Chain of cells, highest priority in cell 0.
	for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
		logic                     prev_geq;
		logic [PRIORITY_BITS-1:0] prev_key;
		logic [PAYLOAD_BITS-1:0]  prev_pay;
		logic [PRIORITY_BITS-1:0] next_key;
		logic [PAYLOAD_BITS-1:0]  next_pay;

		if (j == 0) begin : g_head
			assign prev_geq = 1'b1;
			assign prev_key = new_key;
			assign prev_pay = new_pay;
		end else begin : g_body
			assign prev_geq = cell_geq[j-1];
			assign prev_key = cell_key[j-1];
			assign prev_pay = cell_pay[j-1];
		end

		// The last cell refills from itself on a get; it falls outside the count anyway.
		if (j == CAPACITY - 1) begin : g_tail
			assign next_key = cell_key[j];
			assign next_pay = cell_pay[j];
		end else begin : g_link
			assign next_key = cell_key[j+1];
			assign next_pay = cell_pay[j+1];
		end

		spq_cell #(
			.PRIO_W (PRIORITY_BITS),
			.PAY_W  (PAYLOAD_BITS)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.valid    (CNT_W'(j) < count_q),
			.new_key  (new_key),
			.new_pay  (new_pay),
			.prev_geq (prev_geq),
			.prev_key (prev_key),
			.prev_pay (prev_pay),
			.next_key (next_key),
			.next_pay (next_pay),
			.key      (cell_key[j]),
			.pay      (cell_pay[j]),
			.geq      (cell_geq[j])
		);
	end

	assign top_ext     = {{PAY_OUT_W{1'b0}}, cell_pay[0]};
	assign out_payload = found ? top_ext[PAY_OUT_W-1:0] : '0;
	assign cnt_ext     = {{COUNT_W{1'b0}}, count_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q   <= count_d;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Load the result with the transfer; hold it while the receiver stalls.
	always_ff @(posedge clk) begin
		if (accept) begin
			m_data_q <= {6'b0, dropped, (count_d == '0), cnt_ext[COUNT_W-1:0], found,
				out_payload};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

// ===== hw/rtl/spq_checker.sv =====
// Port-level checker of the sorted priority queue and its bind.
`include "sorted_priority_queue_assert.svh"

module spq_checker
	import spq_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	// A request transfer presents its result in the next cycle.
	`SPQ_ASSERT_NEXT(a_result, clk, arst_n, s_tvalid && s_tready, m_tvalid)

	// A stalled result must hold its value.
	`SPQ_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// The empty flag agrees with the reported count.
	`SPQ_ASSERT_NOW(a_empty, clk, arst_n, m_tvalid, m_tdata[40] == (m_tdata[39:33] == 7'd0))

	// A refused put never reports a found entry.
	`SPQ_ASSERT_NOW(a_drop, clk, arst_n, m_tvalid, !(m_tdata[32] && m_tdata[41]))

	// Without a found entry the payload reads as zero.
	`SPQ_ASSERT_NOW(a_zero, clk, arst_n, m_tvalid && !m_tdata[32], m_tdata[31:0] == 32'd0)

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/sv/sorted_priority_queue_test.sv =====
// Self-checking stream testbench for the sorted priority queue.
module sorted_priority_queue_test;
	timeunit 1ns;
	timeprecision 1ps;
	import spq_pkg::*;

	localparam int CAPACITY     = 64;
	localparam int NUM_RANDOM   = 1950;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int IDLE_PCT     = 35;
	// Window of cycles in which neither side idles.
	localparam int CALM_FROM    = 1200;
	localparam int CALM_TO      = 2000;

	// One request as queued for the driver; hold makes the driver wait for an empty
	// scoreboard before it presents the request.
	typedef struct {
		opcode_t     op;
		logic [31:0] prio;
		logic [31:0] pay;
		bit          hold;
	} request_t;

	// Result fields, last field in the lowest bits as on m_tdata.
	typedef struct packed {
		logic                 dropped;
		logic                 is_empty;
		logic [COUNT_W-1:0]   count;
		logic                 found;
		logic [PAY_OUT_W-1:0] payload;
	} outcome_t;

	typedef struct {
		logic signed [31:0] prio;
		logic [31:0]        pay;
	} entry_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [OPCODE_W-1:0]  s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	request_t request_q[$];        // requests waiting for the driver
	outcome_t pending_results[$];  // results due from the block, oldest first
	entry_t   sorted_entries[$];   // mirror of the queue contents, top entry last

	int  cyc = 0;
	int  idle_run = 0;
	int  errors = 0;
	int  est_count = 0;            // occupancy as the stimulus generator sees it
	int  est_drops = 0;
	int  queued = 0;
	bit  hold_next = 1'b0;
	bit  calm;

	assign calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

	sorted_priority_queue #(
		.CAPACITY      (CAPACITY),
		.PRIORITY_BITS (32),
		.PAYLOAD_BITS  (32)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #6 clk = ~clk;

	// Apply one request to the mirror and return the result it must produce.
	function automatic outcome_t apply_request(opcode_t op, logic signed [31:0] prio,
			logic [31:0] pay);
		outcome_t r;
		entry_t   e;
		int       pos;
		r = '0;
		case (op)
			OPC_PUT: begin
				if (sorted_entries.size() >= CAPACITY) begin
					r.dropped = 1'b1;
				end else begin
					// Insert below the first entry of equal or higher priority, so the
					// oldest of equal priorities stays nearest the top.
					pos = 0;
					while (pos < sorted_entries.size() && sorted_entries[pos].prio < prio)
						pos++;
					e.prio = prio;
					e.pay  = pay;
					sorted_entries.insert(pos, e);
				end
			end
			OPC_GET, OPC_PEEK: begin
				if (sorted_entries.size() != 0) begin
					r.found   = 1'b1;
					r.payload = sorted_entries[$].pay;
					if (op == OPC_GET)
						void'(sorted_entries.pop_back());
				end
			end
			default: ;
		endcase
		r.count    = COUNT_W'(sorted_entries.size());
		r.is_empty = (sorted_entries.size() == 0);
		return r;
	endfunction

	function automatic void log_error(string msg);
		errors++;
		if (errors <= 10)
			$display("[%0t] ERROR: %s", $time, msg);
	endfunction

	function automatic void compare_result(outcome_t want, outcome_t got);
		if (got.payload !== want.payload)
			log_error($sformatf("out_payload: expected %h, got %h", want.payload, got.payload));
		if (got.found !== want.found)
			log_error($sformatf("found: expected %b, got %b", want.found, got.found));
		if (got.count !== want.count)
			log_error($sformatf("entry_count: expected %0d, got %0d", want.count, got.count));
		if (got.is_empty !== want.is_empty)
			log_error($sformatf("is_empty: expected %b, got %b", want.is_empty, got.is_empty));
		if (got.dropped !== want.dropped)
			log_error($sformatf("dropped: expected %b, got %b", want.dropped, got.dropped));
	endfunction

	// Queue one request and track the occupancy it leads to.
	function automatic void queue_request(opcode_t op, logic [31:0] prio, logic [31:0] pay);
		request_t req;
		req.op   = op;
		req.prio = prio;
		req.pay  = pay;
		req.hold = hold_next;
		hold_next = 1'b0;
		request_q.push_back(req);
		queued++;
		if (op == OPC_PUT) begin
			if (est_count < CAPACITY)
				est_count++;
			else
				est_drops++;
		end else if (op == OPC_GET && est_count > 0) begin
			est_count--;
		end
	endfunction

	// Mix extremes, a narrow band that forces ties, and full-range values.
	function automatic logic [31:0] pick_prio();
		case ($urandom_range(9))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2, 3:    return 32'($urandom_range(6)) - 32'd3;
			default: return $urandom;
		endcase
	endfunction

	// Present the next request; hold tvalid until the transfer completes.
	always @(posedge clk or negedge arst_n) begin
		request_t req;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (request_q.size() != 0
					&& (!request_q[0].hold
						|| (!(s_tvalid && s_tready) && pending_results.size() == 0))
					&& (calm || $urandom_range(99) >= IDLE_PCT)) begin
				req = request_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {req.pay, req.prio};
				s_tuser  <= req.op;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Stall the result stream at random outside the calm window.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Predict on every request transfer, check on every result transfer.
	always @(posedge clk) begin
		outcome_t got;
		outcome_t want;
		if (arst_n) begin
			cyc <= cyc + 1;
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_run <= 0;
			else
				idle_run <= idle_run + 1;
			if (m_tvalid && m_tready) begin
				got = outcome_t'(m_tdata[41:0]);
				if (pending_results.size() == 0) begin
					log_error($sformatf("result with nothing expected: %h", m_tdata));
				end else begin
					want = pending_results.pop_front();
					compare_result(want, got);
				end
			end
			if (s_tvalid && s_tready)
				pending_results.push_back(apply_request(opcode_t'(s_tuser),
					s_tdata[31:0], s_tdata[63:32]));
		end
	end

	initial begin
		bit first_phase;
		int base;
		int n;
		int r;

		// Directed: empty-queue reads, the unused opcode, priority extremes, ties.
		queue_request(OPC_GET,  32'd0, 32'hFFFF_FFFF);
		queue_request(OPC_PEEK, 32'd0, 32'hFFFF_FFFF);
		queue_request(OPC_NONE, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		queue_request(OPC_PUT,  32'h8000_0000, 32'h0000_0000);
		queue_request(OPC_PUT,  32'h7FFF_FFFF, 32'hFFFF_FFFF);
		queue_request(OPC_PUT,  32'hFFFF_FFFF, 32'h1111_1111);
		queue_request(OPC_PUT,  32'd0,         32'h2222_2222);
		queue_request(OPC_PUT,  32'd1,         32'h3333_3333);
		queue_request(OPC_PUT,  32'd5,         32'hAAAA_0001);
		queue_request(OPC_PUT,  32'd5,         32'hAAAA_0002);
		queue_request(OPC_PUT,  32'd5,         32'hAAAA_0003);
		queue_request(OPC_PEEK, 32'd0, 32'd0);
		queue_request(OPC_GET,  32'd0, 32'd0);
		queue_request(OPC_NONE, 32'd0, 32'd0);
		for (int i = 0; i < 8; i++)
			queue_request(OPC_GET, 32'd0, 32'd0);
		queue_request(OPC_PEEK, 32'd0, 32'd0);
		queue_request(OPC_GET,  32'd0, 32'd0);

		// Random phases of well-formed fill, drain, tie and mixed traffic.
		first_phase = 1'b1;
		base = queued;
		while (queued - base < NUM_RANDOM) begin
			// Pause the sender for an empty scoreboard ahead of some phases.
			hold_next = first_phase || ($urandom_range(5) == 0);
			first_phase = 1'b0;
			case ($urandom_range(3))
				0: begin
					// Fill until a few puts bounce off the full queue.
					n = est_drops + $urandom_range(1, 4);
					while (est_drops < n)
						queue_request(($urandom_range(9) == 0) ? OPC_PEEK : OPC_PUT,
							pick_prio(), $urandom);
				end
				1: begin
					// Drain to empty, then read the empty queue.
					while (est_count > 0)
						queue_request(($urandom_range(9) == 0) ? OPC_PEEK : OPC_GET,
							pick_prio(), $urandom);
					n = $urandom_range(1, 3);
					for (int i = 0; i < n; i++)
						queue_request($urandom_range(1) ? OPC_GET : OPC_PEEK, $urandom, $urandom);
				end
				2: begin
					for (int i = 0; i < 40; i++) begin
						r = $urandom_range(99);
						if (r < 45)
							queue_request(OPC_PUT, pick_prio(), $urandom);
						else if (r < 80)
							queue_request(OPC_GET, $urandom, $urandom);
						else if (r < 95)
							queue_request(OPC_PEEK, $urandom, $urandom);
						else
							queue_request(OPC_NONE, $urandom, $urandom);
					end
				end
				default: begin
					// Many equal priorities, then take some back out.
					for (int i = 0; i < 16; i++)
						queue_request(OPC_PUT, 32'($urandom_range(2)) - 32'd1, $urandom);
					n = $urandom_range(4, 16);
					for (int i = 0; i < n; i++)
						queue_request(OPC_GET, $urandom, $urandom);
				end
			endcase
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for the last transfer on both sides or a stalled run.
		do
			@(negedge clk);
		while (!(request_q.size() == 0 && !s_tvalid && pending_results.size() == 0)
			&& idle_run < STALL_LIMIT);
		if (idle_run < STALL_LIMIT)
			repeat (DRAIN_CYCLES) @(negedge clk);
		if (pending_results.size() != 0)
			log_error($sformatf("%0d results never arrived", pending_results.size()));

		if (idle_run >= STALL_LIMIT || errors != 0)
			$display("SCOREBOARD MISMATCH");
		else
			$display("SCOREBOARD CLEAN");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue.sv
hw/rtl/spq_checker.sv
tb/sv/sorted_priority_queue_test.sv
